### src/tab_separated_line_tokenizer_assert.svh
// Assertion macros for the tokenizer. Each clocks on clk and is disabled in reset.
`ifndef TAB_SEPARATED_LINE_TOKENIZER_ASSERT_SVH
`define TAB_SEPARATED_LINE_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define TSLT_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tokenizer assertion failed");
`define TSLT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");
`define TSLT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");
`else
`define TSLT_ASSERT(lbl, cond)
`define TSLT_ASSERT_IMP(lbl, ante, cons)
`define TSLT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/tslt_pkg.sv
package tslt_pkg;

	localparam int LINE_BYTES  = 4096;
	localparam int FIELD_SLOTS = 16;

	localparam int POS_W = $clog2(LINE_BYTES);
	localparam int OFF_W = 12;
	localparam int FLD_W = 4;
	localparam int CNT_W = 32;

	// Effective ceiling on the field count: the slot count, but never above 16.
	localparam int FIELD_LIMIT = (FIELD_SLOTS < 16) ? FIELD_SLOTS : 16;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_BYTES - 1);

	localparam logic [7:0] BYTE_TAB   = 8'd9;
	localparam logic [7:0] BYTE_LF    = 8'd10;
	localparam logic [7:0] BYTE_SPACE = 8'd32;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_TOO_FEW   = 2'd1,
		STATUS_TOO_LONG  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_MAX_FIELDS     = 2'd0,
		REG_MIN_FIELDS     = 2'd1,
		REG_COMMENT_CHAR   = 2'd2,
		REG_COMMENT_ENABLE = 2'd3
	} reg_index_t;

endpackage

### src/tab_separated_line_tokenizer.sv
// Splits a byte stream into lines and lines into tab-separated fields.
// Input channel: byte_valid/byte_stall carry data_byte and end_of_data; a
// transaction happens at a clock edge with valid high and stall low. With
// end_of_data high the byte is ignored and any pending line is closed.
// Output channel: field_valid/field_stall carry one result per closed field:
// field_number, field_offset, field_size, line_done, status, record_number.
// Bytes that close no field produce no output transaction.
// A byte is captured in the input register, the line logic works on it
// combinationally and its result is loaded into the output register when
// the input register advances, which raises field_valid.
// Throughput: one byte per cycle when not stalled; the line state is updated by a
// single level of compare and increment logic between the two registers.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more byte; after that byte_stall rises
// until the result is taken. Stall on the input depends on field_stall.
// Configuration writes (cfg_write_en, cfg_index, cfg_data) take effect at once;
// the user must make them only while the block is idle; it does not enforce this.
// Reset (arst_n low) empties both registers, restores the register defaults
// and clears the line state and the accepted line count.
module tab_separated_line_tokenizer
	import tslt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   cfg_write_en,
	input  logic [1:0]             cfg_index,
	input  logic [7:0]             cfg_data,

	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_data,

	output logic                   field_valid,
	input  logic                   field_stall,
	output logic [FLD_W-1:0]       field_number,
	output logic [OFF_W-1:0]       field_offset,
	output logic [OFF_W-1:0]       field_size,
	output logic                   line_done,
	output logic [1:0]             status,
	output logic [CNT_W-1:0]       record_number
);

`include "tab_separated_line_tokenizer_assert.svh"

	// Configuration registers
	logic [4:0] max_fields_q;
	logic [4:0] min_fields_q;
	logic [7:0] comment_char_q;
	logic       comment_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fields_q     <= 5'd6;
			min_fields_q     <= 5'd3;
			comment_char_q   <= 8'd35;
			comment_enable_q <= 1'b1;
		end else if (cfg_write_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_MAX_FIELDS:     max_fields_q     <= cfg_data[4:0];
				REG_MIN_FIELDS:     min_fields_q     <= cfg_data[4:0];
				REG_COMMENT_CHAR:   comment_char_q   <= cfg_data;
				REG_COMMENT_ENABLE: comment_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register
	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       end_of_data_s1;
	logic       advance;
	logic       byte_accept;

	assign advance     = valid_s1 && (!field_valid || !field_stall);
	assign byte_stall  = valid_s1 && !advance;
	assign byte_accept = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_accept) begin
			data_byte_s1   <= data_byte;
			end_of_data_s1 <= end_of_data;
		end
	end

	// Line state
	logic [POS_W-1:0] line_pos_q;
	logic [FLD_W-1:0] cur_field_q;
	logic [POS_W-1:0] field_start_q;
	logic             lead_q;
	logic             dropping_q;
	logic [CNT_W-1:0] accepted_q;

	logic [POS_W-1:0] line_pos_d;
	logic [FLD_W-1:0] cur_field_d;
	logic [POS_W-1:0] field_start_d;
	logic             lead_d;
	logic             dropping_d;
	logic [CNT_W-1:0] accepted_d;

	logic             emit;
	logic             emit_done;
	status_t          emit_status;

	logic [4:0]       max_eff;
	logic [4:0]       min_eff;
	logic [4:0]       field_count;
	logic             terminator;
	logic             blank_drop;
	logic [POS_W-1:0] pos_inc;

	always_comb begin
		if (max_fields_q == 5'd0) begin
			max_eff = 5'd1;
		end else if (max_fields_q > 5'(FIELD_LIMIT)) begin
			max_eff = 5'(FIELD_LIMIT);
		end else begin
			max_eff = max_fields_q;
		end
		min_eff = (min_fields_q < max_eff) ? min_fields_q : max_eff;
	end

	assign field_count = {1'b0, cur_field_q} + 5'd1;
	assign terminator  = end_of_data_s1 || (data_byte_s1 == BYTE_LF);
	assign pos_inc     = line_pos_q + POS_W'(1);
	// A line of only spaces counts as a comment when comments are enabled and the marker is the line feed.
	assign blank_drop  = lead_q && comment_enable_q && (comment_char_q == BYTE_LF);

	always_comb begin
		line_pos_d    = line_pos_q;
		cur_field_d   = cur_field_q;
		field_start_d = field_start_q;
		lead_d        = lead_q;
		dropping_d    = dropping_q;
		accepted_d    = accepted_q;
		emit          = 1'b0;
		emit_done     = 1'b0;
		emit_status   = STATUS_OK;

		if (terminator) begin
			if (!dropping_q && (line_pos_q != '0) && !blank_drop) begin
				emit      = 1'b1;
				emit_done = 1'b1;
				if (field_count < min_eff) begin
					emit_status = STATUS_TOO_FEW;
				end else if (accepted_q != '1) begin
					accepted_d = accepted_q + CNT_W'(1);
				end
			end
			line_pos_d    = '0;
			cur_field_d   = '0;
			field_start_d = '0;
			lead_d        = 1'b1;
			dropping_d    = 1'b0;
		end else if (dropping_q) begin
			// Rest of a dropped line is discarded.
		end else if (line_pos_q >= POS_LAST) begin
			dropping_d  = 1'b1;
			emit        = 1'b1;
			emit_done   = 1'b1;
			emit_status = STATUS_TOO_LONG;
		end else if (lead_q && (data_byte_s1 == BYTE_SPACE)) begin
			line_pos_d    = pos_inc;
			field_start_d = pos_inc;
		end else if (lead_q && comment_enable_q && (data_byte_s1 == comment_char_q)) begin
			lead_d     = 1'b0;
			dropping_d = 1'b1;
		end else if ((data_byte_s1 == BYTE_TAB) && (field_count < max_eff)) begin
			lead_d        = 1'b0;
			emit          = 1'b1;
			cur_field_d   = cur_field_q + FLD_W'(1);
			line_pos_d    = pos_inc;
			field_start_d = pos_inc;
		end else begin
			lead_d     = 1'b0;
			line_pos_d = pos_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pos_q    <= '0;
			cur_field_q   <= '0;
			field_start_q <= '0;
			lead_q        <= 1'b1;
			dropping_q    <= 1'b0;
			accepted_q    <= '0;
		end else if (advance) begin
			line_pos_q    <= line_pos_d;
			cur_field_q   <= cur_field_d;
			field_start_q <= field_start_d;
			lead_q        <= lead_d;
			dropping_q    <= dropping_d;
			accepted_q    <= accepted_d;
		end
	end

	// Output register
	logic             field_valid_q;
	logic [FLD_W-1:0] field_number_q;
	logic [OFF_W-1:0] field_offset_q;
	logic [OFF_W-1:0] field_size_q;
	logic             line_done_q;
	logic [1:0]       status_q;
	logic [CNT_W-1:0] record_number_q;
	logic [POS_W-1:0] size_raw;

	assign size_raw = line_pos_q - field_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_valid_q <= 1'b0;
		end else if (advance) begin
			field_valid_q <= emit;
		end else if (!field_stall) begin
			field_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			field_number_q  <= cur_field_q;
			field_offset_q  <= OFF_W'(field_start_q);
			field_size_q    <= OFF_W'(size_raw);
			line_done_q     <= emit_done;
			status_q        <= emit_status;
			record_number_q <= accepted_q;
		end
	end

	assign field_valid   = field_valid_q;
	assign field_number  = field_number_q;
	assign field_offset  = field_offset_q;
	assign field_size    = field_size_q;
	assign line_done     = line_done_q;
	assign status        = status_q;
	assign record_number = record_number_q;

	`TSLT_ASSERT_IMP(a_status_only_at_line_end, field_valid && (status != STATUS_OK), line_done)
	`TSLT_ASSERT_IMP(a_stall_needs_full_input, byte_stall, valid_s1)
	`TSLT_ASSERT(a_start_within_line, field_start_q <= line_pos_q)
	`TSLT_ASSERT_NEXT(a_count_monotonic, 1'b1, accepted_q >= $past(accepted_q))

endmodule
